### rtl/iaid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iaid_pkg
// Shared codes and field widths of the indexed array insert/delete unit.
// ----------------------------------------------------------------------------
package iaid_pkg;

  localparam int KIND_W  = 2;
  localparam int SLOT_W  = 6;
  localparam int WORD_W  = 32;
  localparam int STAT_W  = 2;
  localparam int POS_W   = 6;
  localparam int FILL_W  = 7;

  // Display streams at most this many elements per request.
  localparam int MAX_OUT = 64;

  localparam logic [KIND_W-1:0] K_INSERT  = 2'd0;
  localparam logic [KIND_W-1:0] K_DELETE  = 2'd1;
  localparam logic [KIND_W-1:0] K_DISPLAY = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd3;

endpackage : iaid_pkg
`default_nettype wire

### rtl/indexed_array_insert_delete_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_array_insert_delete_unit
// Packed array of signed words with insert, delete and display at an index.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one request per transaction:
//   kind, slot and value. The result channel (out_valid/out_ready) returns the
//   results of that request; the final one has out_last set. Insert and
//   delete give one result each, display gives one result per stored element
//   (at most 64), and an empty display gives a single result.
//   Requests are handled one at a time; in_ready is high only while the unit
//   waits for a request. All shifting runs through the single write port and
//   the single registered read port of the element memory, one word a cycle;
//   display streams 1 element a cycle while the receiver takes them.
//   A result waits in the output register while out_ready is low; display
//   then pauses until the element is taken. Reset clears the count and the
//   running sum; the memory contents are not cleared and need no sweep.
// ----------------------------------------------------------------------------
module indexed_array_insert_delete_unit
  import iaid_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic        [KIND_W-1:0]  in_kind,
  input  wire logic        [SLOT_W-1:0]  in_slot,
  input  wire logic signed [WORD_W-1:0]  in_value,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic             [STAT_W-1:0]  out_status,
  output logic signed      [WORD_W-1:0]  out_element,
  output logic             [POS_W-1:0]   out_position,
  output logic                           out_last,
  output logic             [FILL_W-1:0]  out_fill,
  output logic signed      [WORD_W-1:0]  out_total
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  // Compare width: holds the count plus two and the display limit.
  localparam int CMPW = ((CW > FILL_W) ? CW : FILL_W) + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_INS    = 3'd1;
  localparam logic [2:0] S_INSFIN = 3'd2;
  localparam logic [2:0] S_DEL0   = 3'd3;
  localparam logic [2:0] S_DSH    = 3'd4;
  localparam logic [2:0] S_DISP   = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0]               state_r, state_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic signed [WORD_W-1:0] sum_r, sum_nxt;
  logic [AW-1:0]            idx_r, idx_nxt;
  logic [AW-1:0]            slot_r, slot_nxt;
  logic [WORD_W-1:0]        value_r, value_nxt;
  logic [STAT_W-1:0]        st_r, st_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]        out_status_r, out_status_nxt;
  logic [WORD_W-1:0]        out_element_r, out_element_nxt;
  logic [POS_W-1:0]         out_position_r, out_position_nxt;
  logic                     out_last_r, out_last_nxt;
  logic [FILL_W-1:0]        out_fill_r, out_fill_nxt;
  logic [WORD_W-1:0]        out_total_r, out_total_nxt;

  logic                     wr_en, rd_en;
  logic [AW-1:0]            wr_addr, rd_addr;
  logic [WORD_W-1:0]        wr_data, rd_data;

  logic                     out_free;
  logic [CMPW-1:0]          slot_ext, cnt_ext, idx_ext, sslot_ext, disp_n;

  iaid_ram #(
    .DEPTH (DEPTH),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign slot_ext  = CMPW'(in_slot);
  assign cnt_ext   = CMPW'(count_r);
  assign idx_ext   = CMPW'(idx_r);
  assign sslot_ext = CMPW'(slot_r);
  assign disp_n    = (cnt_ext > CMPW'(MAX_OUT)) ? CMPW'(MAX_OUT) : cnt_ext;
  assign in_ready  = (state_r == S_IDLE);

  always_comb begin
    state_nxt        = state_r;
    count_nxt        = count_r;
    sum_nxt          = sum_r;
    idx_nxt          = idx_r;
    slot_nxt         = slot_r;
    value_nxt        = value_r;
    st_nxt           = st_r;
    wr_en            = 1'b0;
    wr_addr          = idx_r;
    wr_data          = rd_data;
    rd_en            = 1'b0;
    rd_addr          = idx_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_status_nxt   = out_status_r;
    out_element_nxt  = out_element_r;
    out_position_nxt = out_position_r;
    out_last_nxt     = out_last_r;
    out_fill_nxt     = out_fill_r;
    out_total_nxt    = out_total_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EMIT;
          st_nxt    = ST_OK;
          case (in_kind)
            K_INSERT: begin
              if (cnt_ext >= CMPW'(DEPTH)) begin
                st_nxt = ST_FULL;
              end else if (slot_ext > cnt_ext) begin
                st_nxt = ST_BADPOS;
              end else if (slot_ext == cnt_ext) begin
                // Append at the fill level: nothing to shift.
                wr_en     = 1'b1;
                wr_addr   = slot_ext[AW-1:0];
                wr_data   = in_value;
                count_nxt = count_r + CW'(1);
                sum_nxt   = sum_r + in_value;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = AW'(cnt_ext - CMPW'(1));
                idx_nxt   = cnt_ext[AW-1:0];
                slot_nxt  = slot_ext[AW-1:0];
                value_nxt = in_value;
                state_nxt = S_INS;
              end
            end
            K_DELETE: begin
              if (slot_ext >= cnt_ext) begin
                st_nxt = ST_BADPOS;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = slot_ext[AW-1:0];
                idx_nxt   = slot_ext[AW-1:0];
                state_nxt = S_DEL0;
              end
            end
            K_DISPLAY: begin
              if (count_r == '0) begin
                st_nxt = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                idx_nxt   = '0;
                state_nxt = S_DISP;
              end
            end
            default: begin
              st_nxt = ST_OK;
            end
          endcase
        end
      end

      S_INS: begin
        // Move entry idx-1 up to idx while fetching the next lower one.
        wr_en   = 1'b1;
        wr_addr = idx_r;
        wr_data = rd_data;
        if (idx_ext > sslot_ext + CMPW'(1)) begin
          rd_en   = 1'b1;
          rd_addr = AW'(idx_ext - CMPW'(2));
          idx_nxt = AW'(idx_ext - CMPW'(1));
        end else begin
          state_nxt = S_INSFIN;
        end
      end

      S_INSFIN: begin
        wr_en     = 1'b1;
        wr_addr   = slot_r;
        wr_data   = value_r;
        count_nxt = count_r + CW'(1);
        sum_nxt   = sum_r + $signed(value_r);
        st_nxt    = ST_OK;
        state_nxt = S_EMIT;
      end

      S_DEL0: begin
        // Read data holds the removed word.
        sum_nxt = sum_r - $signed(rd_data);
        if (idx_ext + CMPW'(1) < cnt_ext) begin
          rd_en     = 1'b1;
          rd_addr   = AW'(idx_ext + CMPW'(1));
          state_nxt = S_DSH;
        end else begin
          count_nxt = count_r - CW'(1);
          st_nxt    = ST_OK;
          state_nxt = S_EMIT;
        end
      end

      S_DSH: begin
        wr_en   = 1'b1;
        wr_addr = idx_r;
        wr_data = rd_data;
        if (idx_ext + CMPW'(2) < cnt_ext) begin
          rd_en   = 1'b1;
          rd_addr = AW'(idx_ext + CMPW'(2));
          idx_nxt = AW'(idx_ext + CMPW'(1));
        end else begin
          count_nxt = count_r - CW'(1);
          st_nxt    = ST_OK;
          state_nxt = S_EMIT;
        end
      end

      S_DISP: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_status_nxt   = ST_OK;
          out_element_nxt  = rd_data;
          out_position_nxt = idx_ext[POS_W-1:0];
          out_fill_nxt     = cnt_ext[FILL_W-1:0];
          out_total_nxt    = sum_r;
          if (idx_ext == disp_n - CMPW'(1)) begin
            out_last_nxt = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            out_last_nxt = 1'b0;
            rd_en        = 1'b1;
            rd_addr      = AW'(idx_ext + CMPW'(1));
            idx_nxt      = AW'(idx_ext + CMPW'(1));
          end
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_status_nxt   = st_r;
          out_element_nxt  = '0;
          out_position_nxt = '0;
          out_last_nxt     = 1'b1;
          out_fill_nxt     = cnt_ext[FILL_W-1:0];
          out_total_nxt    = sum_r;
          state_nxt        = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r          <= idx_nxt;
    slot_r         <= slot_nxt;
    value_r        <= value_nxt;
    st_r           <= st_nxt;
    out_status_r   <= out_status_nxt;
    out_element_r  <= out_element_nxt;
    out_position_r <= out_position_nxt;
    out_last_r     <= out_last_nxt;
    out_fill_r     <= out_fill_nxt;
    out_total_r    <= out_total_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_element  = out_element_r;
  assign out_position = out_position_r;
  assign out_last     = out_last_r;
  assign out_fill     = out_fill_r;
  assign out_total    = out_total_r;

endmodule : indexed_array_insert_delete_unit
`default_nettype wire

### rtl/iaid_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iaid_ram
// Simple dual-port memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
module iaid_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds its value until the next read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : iaid_ram
`default_nettype wire

### rtl/iaid_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iaid_checker
// Port-level assertions for the indexed array insert/delete unit.
// ----------------------------------------------------------------------------
module iaid_checker
  import iaid_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic        [KIND_W-1:0]  in_kind,
  input wire logic        [SLOT_W-1:0]  in_slot,
  input wire logic signed [WORD_W-1:0]  in_value,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic        [STAT_W-1:0]  out_status,
  input wire logic signed [WORD_W-1:0]  out_element,
  input wire logic        [POS_W-1:0]   out_position,
  input wire logic                      out_last,
  input wire logic        [FILL_W-1:0]  out_fill,
  input wire logic signed [WORD_W-1:0]  out_total
);

  // A waiting request keeps its contents until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_kind) && $stable(in_slot) &&
      $stable(in_value))
    else $error("request changed while waiting");

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_element) && $stable(out_position) && $stable(out_last) &&
      $stable(out_fill) && $stable(out_total))
    else $error("result changed while stalled");

  // Any non-ok status ends its request and carries no element.
  a_reject_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last && out_element == '0 &&
      out_position == '0)
    else $error("rejected request produced a streamed result");

  // An empty display can only be reported with a zero count.
  a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_fill == '0)
    else $error("empty status with nonzero fill");

  // A full rejection reports the array at its depth.
  a_full_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_fill == FILL_W'(DEPTH))
    else $error("full status with fill below depth");

endmodule : iaid_checker

bind indexed_array_insert_delete_unit iaid_checker #(.DEPTH(DEPTH)) u_iaid_checker (.*);
`default_nettype wire

### sim/tb_indexed_array_insert_delete_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_array_insert_delete_unit
// Self-checking bench for the indexed array insert/delete unit. A shadow copy
// of the array, its fill level and its wrapping sum predicts every result of
// each accepted request. A checker compares each returned result field by
// field. Directed cases cover the empty and full array, bad positions and the
// unused request code. Random traffic then fills and drains the array and
// mixes all requests, with bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_indexed_array_insert_delete_unit;
  import iaid_pkg::*;

  localparam int ARRAY_DEPTH = 64;
  localparam int RANDOM_ITEMS = 400;
  localparam logic [KIND_W-1:0] K_UNUSED = 2'd3;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [WORD_W-1:0] element;
    logic [POS_W-1:0]         position;
    logic                     is_last;
    logic [FILL_W-1:0]        fill;
    logic signed [WORD_W-1:0] total;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [KIND_W-1:0] in_kind = '0;
  logic [SLOT_W-1:0] in_slot = '0;
  logic signed [WORD_W-1:0] in_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic signed [WORD_W-1:0] out_element;
  logic [POS_W-1:0] out_position;
  logic out_last;
  logic [FILL_W-1:0] out_fill;
  logic signed [WORD_W-1:0] out_total;

  // Shadow state of the array.
  logic signed [WORD_W-1:0] shadow_words [ARRAY_DEPTH];
  logic [FILL_W-1:0] shadow_fill = '0;
  logic signed [WORD_W-1:0] shadow_sum = '0;

  result_t expected_results [$];
  int error_count = 0;
  int random_items = 0;
  int burst_left = 0;
  int ready_mode = 0;
  int ready_hold = 0;
  int ready_tick = 0;

  indexed_array_insert_delete_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_kind     (in_kind),
    .in_slot     (in_slot),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_status  (out_status),
    .out_element (out_element),
    .out_position(out_position),
    .out_last    (out_last),
    .out_fill    (out_fill),
    .out_total   (out_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  function automatic result_t make_result(logic [STAT_W-1:0] status,
                                          logic signed [WORD_W-1:0] element,
                                          logic [POS_W-1:0] position,
                                          logic is_last);
    result_t r;
    r.status   = status;
    r.element  = element;
    r.position = position;
    r.is_last  = is_last;
    r.fill     = shadow_fill;
    r.total    = shadow_sum;
    return r;
  endfunction

  // Applies one accepted request to the shadow array and queues its results.
  function automatic void apply_array_request(logic [KIND_W-1:0] kind,
                                              logic [SLOT_W-1:0] slot,
                                              logic signed [WORD_W-1:0] value);
    int n;
    case (kind)
      K_INSERT: begin
        if (shadow_fill >= ARRAY_DEPTH) begin
          expected_results.push_back(make_result(ST_FULL, '0, '0, 1'b1));
        end else if (slot > shadow_fill) begin
          expected_results.push_back(make_result(ST_BADPOS, '0, '0, 1'b1));
        end else begin
          for (int i = shadow_fill; i > slot; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[slot] = value;
          shadow_fill = shadow_fill + 1'b1;
          shadow_sum = shadow_sum + value;
          expected_results.push_back(make_result(ST_OK, '0, '0, 1'b1));
        end
      end
      K_DELETE: begin
        if (slot >= shadow_fill) begin
          expected_results.push_back(make_result(ST_BADPOS, '0, '0, 1'b1));
        end else begin
          shadow_sum = shadow_sum - shadow_words[slot];
          for (int i = slot; i + 1 < shadow_fill; i++) shadow_words[i] = shadow_words[i+1];
          shadow_fill = shadow_fill - 1'b1;
          expected_results.push_back(make_result(ST_OK, '0, '0, 1'b1));
        end
      end
      K_DISPLAY: begin
        if (shadow_fill == 0) begin
          expected_results.push_back(make_result(ST_EMPTY, '0, '0, 1'b1));
        end else begin
          n = (shadow_fill > MAX_OUT) ? MAX_OUT : int'(shadow_fill);
          for (int i = 0; i < n; i++) begin
            expected_results.push_back(make_result(ST_OK, shadow_words[i], POS_W'(i),
                                                   i == n - 1));
          end
        end
      end
      default: begin
        expected_results.push_back(make_result(ST_OK, '0, '0, 1'b1));
      end
    endcase
  endfunction

  function automatic void note_error(string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR at %0t: %s", $time, msg);
  endfunction

  // Requests go out in bursts of random length separated by random gaps.
  task automatic send_request(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot,
                              logic signed [WORD_W-1:0] value);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_slot  <= slot;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
    apply_array_request(kind, slot, value);
    burst_left--;
  endtask

  function automatic logic signed [WORD_W-1:0] random_word();
    case ($urandom_range(0, 19))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'sh0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_insert(bit valid_slot);
    logic [SLOT_W-1:0] slot;
    if (valid_slot && shadow_fill < ARRAY_DEPTH) slot = SLOT_W'($urandom_range(0, shadow_fill));
    else slot = SLOT_W'($urandom_range(0, ARRAY_DEPTH - 1));
    send_request(K_INSERT, slot, random_word());
    random_items++;
  endtask

  task automatic send_random_delete(bit valid_slot);
    logic [SLOT_W-1:0] slot;
    if (valid_slot && shadow_fill > 0) slot = SLOT_W'($urandom_range(0, shadow_fill - 1));
    else slot = SLOT_W'($urandom_range(0, ARRAY_DEPTH - 1));
    send_request(K_DELETE, slot, random_word());
    random_items++;
  endtask

  task automatic send_random_other(logic [KIND_W-1:0] kind);
    send_request(kind, SLOT_W'($urandom_range(0, ARRAY_DEPTH - 1)), random_word());
    random_items++;
  endtask

  // Empty array right after reset: every request is rejected or empty, but the unused code returns ok.
  task automatic test_empty_array();
    send_request(K_DISPLAY, 6'd0, 32'sd0);
    send_request(K_DELETE, 6'd0, 32'sd5);
    send_request(K_DELETE, 6'd63, -32'sd1);
    send_request(K_INSERT, 6'd1, 32'sd9);
    send_request(K_UNUSED, 6'd0, 32'sd0);
  endtask

  // Inserts at the front, middle and end with extreme words; the sum wraps.
  task automatic test_insert_positions();
    send_request(K_INSERT, 6'd0, 32'sh7FFF_FFFF);
    send_request(K_INSERT, 6'd1, 32'sh8000_0000);
    send_request(K_INSERT, 6'd0, -32'sd1);
    send_request(K_INSERT, 6'd1, 32'sd0);
    send_request(K_INSERT, 6'd4, 32'sh5555_5555);
    send_request(K_INSERT, 6'd6, 32'sh2AAA_AAAA);
    send_request(K_DISPLAY, 6'd63, 32'sh1234_5678);
    send_request(K_UNUSED, 6'd63, -32'sd1);
  endtask

  task automatic test_delete_positions();
    send_request(K_DELETE, 6'd4, 32'sd0);
    send_request(K_DELETE, 6'd0, 32'sd0);
    send_request(K_DELETE, 6'd1, 32'sd0);
    send_request(K_DELETE, 6'd2, 32'sd0);
    send_request(K_DISPLAY, 6'd0, 32'sd0);
    send_request(K_DELETE, 6'd0, 32'sd0);
    send_request(K_DELETE, 6'd0, 32'sd0);
    send_request(K_DISPLAY, 6'd0, 32'sd0);
  endtask

  // Grows the array to full, pokes it while full, then drains it to empty.
  task automatic test_fill_and_drain();
    int pick;
    while (shadow_fill < ARRAY_DEPTH) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) send_random_insert(1'b1);
      else if (pick < 90) send_random_insert(1'b0);
      else if (pick < 95) send_random_delete(1'b1);
      else send_random_other(K_DISPLAY);
    end
    repeat (3) send_random_insert(1'b0);
    send_random_other(K_DISPLAY);
    send_random_delete(1'b0);
    while (shadow_fill > 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) send_random_delete(1'b1);
      else if (pick < 90) send_random_delete(1'b0);
      else if (pick < 95) send_random_insert(1'b1);
      else send_random_other(K_DISPLAY);
    end
    send_random_other(K_DISPLAY);
  endtask

  task automatic test_random_mix();
    int pick;
    while (random_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) send_random_insert(1'b1);
      else if (pick < 75) send_random_delete(1'b1);
      else if (pick < 85) send_random_other(K_DISPLAY);
      else if (pick < 90) send_random_other(K_UNUSED);
      else if (pick < 95) send_random_insert(1'b0);
      else send_random_delete(1'b0);
    end
  endtask

  // The receiver switches between always ready, random, rare and alternating
  // acceptance, each held for a random number of cycles.
  always @(posedge clk) begin
    if (ready_hold == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_hold = $urandom_range(20, 200);
    end
    ready_hold--;
    ready_tick++;
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 7) == 0);
      default: out_ready <= ready_tick[0];
    endcase
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        note_error($sformatf("unexpected transaction: status %0d element %0d pos %0d",
                             out_status, out_element, out_position));
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status || out_element !== want.element ||
            out_position !== want.position || out_last !== want.is_last ||
            out_fill !== want.fill || out_total !== want.total) begin
          note_error($sformatf({"expected st %0d el %0d pos %0d last %0d fill %0d ",
                                "sum %0d, got st %0d el %0d pos %0d last %0d fill %0d ",
                                "sum %0d"},
                               want.status, want.element, want.position, want.is_last,
                               want.fill, want.total, out_status, out_element,
                               out_position, out_last, out_fill, out_total));
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_array();
    test_insert_positions();
    test_delete_positions();
    test_fill_and_drain();
    test_fill_and_drain();
    test_random_mix();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Worst case is far below this: every display stalled on a slow receiver.
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### files.f
rtl/iaid_pkg.sv
rtl/iaid_ram.sv
rtl/indexed_array_insert_delete_unit.sv
rtl/iaid_checker.sv
sim/tb_indexed_array_insert_delete_unit.sv
